// ===== src/thermostat_mode_controller_unit_assert.svh =====
// Assertion macros shared by the thermostat mode controller RTL.
// Each macro checks one implication on the rising clock edge, off during reset.
`ifndef THERMOSTAT_MODE_CONTROLLER_UNIT_ASSERT_SVH
`define THERMOSTAT_MODE_CONTROLLER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TMC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TMC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tmc_pkg.sv =====
// Package of the thermostat mode controller: mode and opcode codes,
// temperature limits, register map and the structs passed between modules.
// No dependencies.
`default_nettype none

package tmc_pkg;

    localparam int FAULT_BITS_DEFAULT = 8;

    localparam int TEMP_MAX  = 2000;
    localparam int TEMP_MIN  = -2000;
    localparam int TEMP_STEP = 5;

    localparam int MS_PER_S     = 1000;
    localparam int TIMEOUT_S_W  = 16;
    localparam int TIMEOUT_MS_W = 26;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_START_TARGET = 2'd0;
    localparam logic [1:0] REG_HYST_BAND    = 2'd1;
    localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd2;

    localparam logic signed [11:0] START_TARGET_RST = 12'sd600;
    localparam logic [7:0]         HYST_BAND_RST    = 8'd10;

    typedef enum logic [2:0] {
        MODE_BOOT     = 3'd0,
        MODE_IDLE     = 3'd1,
        MODE_HEATING  = 3'd2,
        MODE_MAINTAIN = 3'd3,
        MODE_ALARM    = 3'd4,
        MODE_SLEEP    = 3'd5
    } mode_t;

    typedef enum logic [3:0] {
        OP_POLL       = 4'd0,
        OP_POWER      = 4'd1,
        OP_UP         = 4'd2,
        OP_DOWN       = 4'd3,
        OP_ENTER_SET  = 4'd4,
        OP_EXIT_SET   = 4'd5,
        OP_SAVE       = 4'd6,
        OP_ALARM_ACK  = 4'd7,
        OP_WAKEUP     = 4'd8
    } op_t;

    typedef struct packed {
        logic signed [11:0]      start_target;
        logic [7:0]              band;
        logic [TIMEOUT_MS_W-1:0] timeout_ms;
    } cfg_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [11:0] target;
        logic [31:0]        last_ms;
        logic               backlight;
        logic               page;
    } ctl_state_t;

    typedef struct packed {
        logic load_off;
        logic pid_rst;
        logic fault_clr;
        logic save;
        logic alarm;
    } pulse_t;

endpackage

`default_nettype wire

// ===== src/thermostat_mode_controller_unit.sv =====
// Thermostat mode controller: one result transfer for every input transfer, one
// transfer per clock when the result side keeps up; each item passes the input
// register, then the result register. The longest path is the 32-bit idle
// elapsed-time compare and the 13-bit hysteresis compare feeding the mode
// select. The idle timeout is converted to milliseconds when written, so no
// multiply lies in the per-item path. No clearing pass is needed after reset.
// Depends on tmc_pkg, tmc_cfg, tmc_step and the assert header.
`default_nettype none

`include "thermostat_mode_controller_unit_assert.svh"

module thermostat_mode_controller_unit #(
    parameter int FAULT_BITS = tmc_pkg::FAULT_BITS_DEFAULT
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,

    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [3:0]                 s_opcode,
    input  wire logic [31:0]                s_now_ms,
    input  wire logic signed [11:0]         s_chamber_temp,
    input  wire logic [FAULT_BITS-1:0]      s_fault_bits,

    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [2:0]                      m_mode,
    output logic signed [11:0]              m_setpoint,
    output logic [FAULT_BITS-1:0]           m_latched_fault,
    output logic                            m_load_off_pulse,
    output logic                            m_pid_reset_pulse,
    output logic                            m_fault_clear_pulse,
    output logic                            m_save_pulse,
    output logic                            m_panel_lit,
    output logic                            m_page_select,
    output logic                            m_alarm_pulse,

    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [tmc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tmc_pkg::DATA_W-1:0] pwdata,
    output logic      [tmc_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);

    tmc_pkg::cfg_t          cfg;

    logic                   in_valid_reg;
    logic [3:0]             op_reg;
    logic [31:0]            now_reg;
    logic signed [11:0]     temp_reg;
    logic [FAULT_BITS-1:0]  faults_reg;

    tmc_pkg::ctl_state_t    state_reg;
    tmc_pkg::ctl_state_t    state_next;
    logic [FAULT_BITS-1:0]  fault_reg;
    logic [FAULT_BITS-1:0]  fault_next;
    tmc_pkg::pulse_t        pulses;

    logic                   out_valid_reg;
    tmc_pkg::ctl_state_t    out_state_reg;
    logic [FAULT_BITS-1:0]  out_fault_reg;
    tmc_pkg::pulse_t        out_pulse_reg;

    logic                   advance;
    logic                   in_take;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;

    tmc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tmc_step #(
        .FAULT_BITS (FAULT_BITS)
    ) u_step (
        .state_cur    (state_reg),
        .fault_cur    (fault_reg),
        .cfg          (cfg),
        .opcode       (op_reg),
        .now_ms       (now_reg),
        .chamber_temp (temp_reg),
        .fault_bits   (faults_reg),
        .state_next   (state_next),
        .fault_next   (fault_next),
        .pulses       (pulses)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            op_reg     <= s_opcode;
            now_reg    <= s_now_ms;
            temp_reg   <= s_chamber_temp;
            faults_reg <= s_fault_bits;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode      <= tmc_pkg::MODE_BOOT;
            state_reg.target    <= '0;
            state_reg.last_ms   <= '0;
            state_reg.backlight <= 1'b1;
            state_reg.page      <= 1'b0;
            fault_reg           <= '0;
        end else if (advance) begin
            state_reg <= state_next;
            fault_reg <= fault_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_state_reg <= state_next;
            out_fault_reg <= fault_next;
            out_pulse_reg <= pulses;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_mode              = out_state_reg.mode;
    assign m_setpoint          = out_state_reg.target;
    assign m_latched_fault     = out_fault_reg;
    assign m_load_off_pulse    = out_pulse_reg.load_off;
    assign m_pid_reset_pulse   = out_pulse_reg.pid_rst;
    assign m_fault_clear_pulse = out_pulse_reg.fault_clr;
    assign m_save_pulse        = out_pulse_reg.save;
    assign m_panel_lit         = out_state_reg.backlight;
    assign m_page_select       = out_state_reg.page;
    assign m_alarm_pulse       = out_pulse_reg.alarm;

    `TMC_ASSERT_SAME(a_alarm_sets_mode, aclk, aresetn,
        m_valid && m_alarm_pulse,
        out_state_reg.mode == tmc_pkg::MODE_ALARM && m_load_off_pulse,
        "Alarm transfer without alarm mode and load off.")
    `TMC_ASSERT_SAME(a_pid_reset_heats, aclk, aresetn,
        m_valid && m_pid_reset_pulse,
        out_state_reg.mode == tmc_pkg::MODE_HEATING,
        "Regulator reset outside heating.")
    `TMC_ASSERT_SAME(a_ack_clears, aclk, aresetn,
        m_valid && m_fault_clear_pulse,
        m_latched_fault == '0 && out_state_reg.mode == tmc_pkg::MODE_IDLE,
        "Alarm acknowledge left a fault or a mode other than idle.")
    `TMC_ASSERT_NEXT(a_boot_left, aclk, aresetn,
        advance,
        state_reg.mode != tmc_pkg::MODE_BOOT,
        "Controller still in boot after processing a transfer.")
    `TMC_ASSERT_NEXT(a_item_kept, aclk, aresetn,
        in_valid_reg && !advance,
        in_valid_reg,
        "Pending input transfer dropped while the result side stalled.")

endmodule

`default_nettype wire

// ===== src/tmc_cfg.sv =====
// Configuration register file of the thermostat mode controller, APB-style port.
// Keeps the idle timeout also in milliseconds. Depends on tmc_pkg.
`default_nettype none

module tmc_cfg (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [tmc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tmc_pkg::DATA_W-1:0] pwdata,
    output logic      [tmc_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output tmc_pkg::cfg_t                   cfg
);

    logic signed [11:0]                    start_target_reg;
    logic [7:0]                            band_reg;
    logic [tmc_pkg::TIMEOUT_S_W-1:0]       timeout_s_reg;
    logic [tmc_pkg::TIMEOUT_MS_W-1:0]      timeout_ms_reg;
    logic [tmc_pkg::TIMEOUT_MS_W-1:0]      timeout_ms_next;
    logic                                  wr_en;
    logic [1:0]                            reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    assign timeout_ms_next = tmc_pkg::TIMEOUT_MS_W'(pwdata[tmc_pkg::TIMEOUT_S_W-1:0])
                           * tmc_pkg::TIMEOUT_MS_W'(tmc_pkg::MS_PER_S);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_target_reg <= tmc_pkg::START_TARGET_RST;
            band_reg         <= tmc_pkg::HYST_BAND_RST;
            timeout_s_reg    <= '0;
            timeout_ms_reg   <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                tmc_pkg::REG_START_TARGET: begin
                    start_target_reg <= pwdata[11:0];
                end
                tmc_pkg::REG_HYST_BAND: begin
                    band_reg <= pwdata[7:0];
                end
                tmc_pkg::REG_IDLE_TIMEOUT: begin
                    timeout_s_reg  <= pwdata[tmc_pkg::TIMEOUT_S_W-1:0];
                    timeout_ms_reg <= timeout_ms_next;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            tmc_pkg::REG_START_TARGET: prdata = tmc_pkg::DATA_W'(start_target_reg);
            tmc_pkg::REG_HYST_BAND:    prdata = tmc_pkg::DATA_W'(band_reg);
            tmc_pkg::REG_IDLE_TIMEOUT: prdata = tmc_pkg::DATA_W'(timeout_s_reg);
            default:                   prdata = '0;
        endcase
    end

    assign cfg.start_target = start_target_reg;
    assign cfg.band         = band_reg;
    assign cfg.timeout_ms   = timeout_ms_reg;

endmodule

`default_nettype wire

// ===== src/tmc_step.sv =====
// Next-state and result logic of the thermostat mode controller for one item.
// Purely combinational. Depends on tmc_pkg.
`default_nettype none

module tmc_step #(
    parameter int FAULT_BITS = tmc_pkg::FAULT_BITS_DEFAULT
) (
    input  wire tmc_pkg::ctl_state_t        state_cur,
    input  wire logic [FAULT_BITS-1:0]      fault_cur,
    input  wire tmc_pkg::cfg_t              cfg,
    input  wire logic [3:0]                 opcode,
    input  wire logic [31:0]                now_ms,
    input  wire logic signed [11:0]         chamber_temp,
    input  wire logic [FAULT_BITS-1:0]      fault_bits,
    output tmc_pkg::ctl_state_t             state_next,
    output logic [FAULT_BITS-1:0]           fault_next,
    output tmc_pkg::pulse_t                 pulses
);

    function automatic logic signed [11:0] clamp_temp(input logic signed [12:0] v);
        logic signed [11:0] r;
        if (v > 13'(tmc_pkg::TEMP_MAX)) begin
            r = 12'(tmc_pkg::TEMP_MAX);
        end else if (v < 13'(tmc_pkg::TEMP_MIN)) begin
            r = 12'(tmc_pkg::TEMP_MIN);
        end else begin
            r = v[11:0];
        end
        return r;
    endfunction

    tmc_pkg::ctl_state_t    st;
    logic [FAULT_BITS-1:0]  flt;
    tmc_pkg::pulse_t        pl;
    logic signed [12:0]     err;
    logic signed [12:0]     band_pos;
    logic signed [12:0]     band_neg;
    logic [31:0]            elapsed;

    always_comb begin
        st = state_cur;
        flt = fault_cur;
        pl = '0;

        if (state_cur.mode == tmc_pkg::MODE_BOOT) begin
            st.target  = clamp_temp({cfg.start_target[11], cfg.start_target});
            st.last_ms = now_ms;
            st.mode    = tmc_pkg::MODE_IDLE;
        end

        err      = {st.target[11], st.target} - {chamber_temp[11], chamber_temp};
        band_pos = $signed({5'b0, cfg.band});
        band_neg = -band_pos;
        elapsed  = now_ms - st.last_ms;

        unique case (opcode)
            tmc_pkg::OP_POLL: begin
                if (st.mode == tmc_pkg::MODE_HEATING || st.mode == tmc_pkg::MODE_MAINTAIN) begin
                    if (err > band_pos) begin
                        st.mode = tmc_pkg::MODE_HEATING;
                    end else if (err < band_neg) begin
                        st.mode = tmc_pkg::MODE_MAINTAIN;
                    end
                end
                if (fault_bits != flt) begin
                    flt = fault_bits;
                    if (fault_bits != '0) begin
                        pl.alarm    = 1'b1;
                        pl.load_off = 1'b1;
                        st.mode     = tmc_pkg::MODE_ALARM;
                    end
                end
                if (st.mode != tmc_pkg::MODE_SLEEP && st.mode != tmc_pkg::MODE_ALARM &&
                    cfg.timeout_ms != '0 && elapsed > 32'(cfg.timeout_ms)) begin
                    st.mode      = tmc_pkg::MODE_SLEEP;
                    st.backlight = 1'b0;
                end
            end
            tmc_pkg::OP_POWER: begin
                if (st.mode == tmc_pkg::MODE_IDLE) begin
                    pl.pid_rst = 1'b1;
                    st.mode    = tmc_pkg::MODE_HEATING;
                end else if (st.mode == tmc_pkg::MODE_HEATING ||
                             st.mode == tmc_pkg::MODE_MAINTAIN) begin
                    pl.load_off = 1'b1;
                    st.mode     = tmc_pkg::MODE_IDLE;
                end
            end
            tmc_pkg::OP_UP: begin
                st.target  = clamp_temp({st.target[11], st.target} + 13'(tmc_pkg::TEMP_STEP));
                st.last_ms = now_ms;
            end
            tmc_pkg::OP_DOWN: begin
                st.target  = clamp_temp({st.target[11], st.target} - 13'(tmc_pkg::TEMP_STEP));
                st.last_ms = now_ms;
            end
            tmc_pkg::OP_ENTER_SET: begin
                st.page    = 1'b1;
                st.last_ms = now_ms;
            end
            tmc_pkg::OP_EXIT_SET: begin
                st.page    = 1'b0;
                st.last_ms = now_ms;
            end
            tmc_pkg::OP_SAVE: begin
                pl.save = 1'b1;
            end
            tmc_pkg::OP_ALARM_ACK: begin
                pl.fault_clr = 1'b1;
                flt          = '0;
                st.mode      = tmc_pkg::MODE_IDLE;
            end
            tmc_pkg::OP_WAKEUP: begin
                st.backlight = 1'b1;
                st.last_ms   = now_ms;
                st.page      = 1'b0;
                st.mode      = tmc_pkg::MODE_IDLE;
            end
            default: begin
            end
        endcase

        state_next = st;
        fault_next = flt;
        pulses     = pl;
    end

endmodule

`default_nettype wire
